// ===== hw/rtl/exyz_pkg.sv =====
`timescale 1ns / 1ps
package exyz_pkg;
    localparam int CW = 40;
    localparam logic signed [CW-1:0] ANG_LIMIT = 40'sd25736;
    localparam logic signed [CW-1:0] PI_Q30 = 40'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 40'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30 = 40'sd652032874;

    typedef logic signed [CW-1:0] t_cw;

    function automatic t_cw atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 40'sd843314856;
            5'd1: atan_q30 = 40'sd497837829;
            5'd2: atan_q30 = 40'sd263043836;
            5'd3: atan_q30 = 40'sd133525158;
            5'd4: atan_q30 = 40'sd66987298;
            5'd5: atan_q30 = 40'sd33522745;
            5'd6: atan_q30 = 40'sd16765412;
            5'd7: atan_q30 = 40'sd8383141;
            5'd8: atan_q30 = 40'sd4191634;
            5'd9: atan_q30 = 40'sd2097149;
            5'd10: atan_q30 = 40'sd1048575;
            5'd11: atan_q30 = 40'sd524287;
            5'd12: atan_q30 = 40'sd262143;
            5'd13: atan_q30 = 40'sd131071;
            5'd14: atan_q30 = 40'sd65535;
            5'd15: atan_q30 = 40'sd32767;
            5'd16: atan_q30 = 40'sd16383;
            5'd17: atan_q30 = 40'sd8191;
            5'd18: atan_q30 = 40'sd4095;
            5'd19: atan_q30 = 40'sd2047;
            5'd20: atan_q30 = 40'sd1023;
            5'd21: atan_q30 = 40'sd511;
            5'd22: atan_q30 = 40'sd255;
            5'd23: atan_q30 = 40'sd127;
            5'd24: atan_q30 = 40'sd63;
            5'd25: atan_q30 = 40'sd31;
            5'd26: atan_q30 = 40'sd15;
            5'd27: atan_q30 = 40'sd8;
            5'd28: atan_q30 = 40'sd4;
            5'd29: atan_q30 = 40'sd2;
            5'd30: atan_q30 = 40'sd1;
            default: atan_q30 = 40'sd0;
        endcase
    endfunction
endpackage

// ===== hw/rtl/exyz_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined sine/cosine of one angle; one register stage per CORDIC step.
module exyz_cordic #(
    parameter int COEF_WIDTH = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [15:0]           i_angle,
    output logic signed [COEF_WIDTH-1:0] o_sin,
    output logic signed [COEF_WIDTH-1:0] o_cos
);
    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int F = COEF_WIDTH - 2;
    localparam int SH = 30 - F;

    exyz_pkg::t_cw r_x [NS+1];
    exyz_pkg::t_cw r_y [NS+1];
    exyz_pkg::t_cw r_a [NS+1];
    logic          r_flip [NS+1];
    logic signed [COEF_WIDTH-1:0] r_s;
    logic signed [COEF_WIDTH-1:0] r_c;

    exyz_pkg::t_cw n_a0;
    logic          n_flip0;
    exyz_pkg::t_cw w_cl;

    always_comb begin
        w_cl = exyz_pkg::t_cw'(i_angle);
        if (w_cl > exyz_pkg::ANG_LIMIT) w_cl = exyz_pkg::ANG_LIMIT;
        if (w_cl < -exyz_pkg::ANG_LIMIT) w_cl = -exyz_pkg::ANG_LIMIT;
        w_cl = w_cl <<< 17;
        n_flip0 = 1'b0;
        n_a0 = w_cl;
        if (w_cl > exyz_pkg::HALF_PI_Q30) begin
            n_a0 = w_cl - exyz_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else if (w_cl < -exyz_pkg::HALF_PI_Q30) begin
            n_a0 = w_cl + exyz_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= exyz_pkg::GAIN_Q30;
            r_y[0] <= '0;
            r_a[0] <= n_a0;
            r_flip[0] <= n_flip0;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[g+1] <= r_flip[g];
                if (!r_a[g][exyz_pkg::CW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] - exyz_pkg::atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] + exyz_pkg::atan_q30(5'(g));
                end
            end
        end
    end

    function automatic logic signed [COEF_WIDTH-1:0] to_coef(input exyz_pkg::t_cw v);
        exyz_pkg::t_cw t;
        t = v;
        if (SH > 0) t = (v + (exyz_pkg::t_cw'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        if (t > (exyz_pkg::t_cw'(1) <<< F)) t = exyz_pkg::t_cw'(1) <<< F;
        if (t < -(exyz_pkg::t_cw'(1) <<< F)) t = -(exyz_pkg::t_cw'(1) <<< F);
        return t[COEF_WIDTH-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= to_coef(r_flip[NS] ? -r_y[NS] : r_y[NS]);
            r_c <= to_coef(r_flip[NS] ? -r_x[NS] : r_x[NS]);
        end
    end

    assign o_sin = r_s;
    assign o_cos = r_c;
endmodule

// ===== hw/rtl/exyz_matrix.sv =====
`timescale 1ns / 1ps
// Three registered stages: cross terms, products, sums.
module exyz_matrix #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COEF_WIDTH-1:0] i_sx, i_cx, i_sy, i_cy, i_sz, i_cz,
    output logic signed [COEF_WIDTH-1:0] o_m [9]
);
    localparam int F = COEF_WIDTH - 2;
    localparam int PW = 2 * COEF_WIDTH + 1;
    typedef logic signed [COEF_WIDTH-1:0] t_c;
    typedef logic signed [PW-1:0] t_p;

    function automatic t_p rmul(input t_c a, input t_c b);
        t_p p;
        p = (t_p'(a) * t_p'(b)) + (t_p'(1) <<< (F - 1));
        return p >>> F;
    endfunction

    function automatic t_c sat(input t_p v);
        t_p t;
        t = v;
        if (t > (t_p'(1) <<< F)) t = t_p'(1) <<< F;
        if (t < -(t_p'(1) <<< F)) t = -(t_p'(1) <<< F);
        return t[COEF_WIDTH-1:0];
    endfunction

    t_c r_sx, r_cx, r_sy, r_cy, r_sz, r_cz, r_sxsy, r_cxsy;
    t_p r_p [14];
    t_c r_m [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= i_sx; r_cx <= i_cx; r_sy <= i_sy;
            r_cy <= i_cy; r_sz <= i_sz; r_cz <= i_cz;
            r_sxsy <= t_c'(rmul(i_sx, i_sy));
            r_cxsy <= t_c'(rmul(i_cx, i_sy));
            r_p[0] <= rmul(r_cy, r_cz);
            r_p[1] <= -rmul(r_cy, r_sz);
            r_p[2] <= t_p'(r_sy);
            r_p[3] <= rmul(r_cx, r_sz);
            r_p[4] <= rmul(r_sxsy, r_cz);
            r_p[5] <= rmul(r_cx, r_cz);
            r_p[6] <= rmul(r_sxsy, r_sz);
            r_p[7] <= -rmul(r_sx, r_cy);
            r_p[8] <= rmul(r_sx, r_sz);
            r_p[9] <= rmul(r_cxsy, r_cz);
            r_p[10] <= rmul(r_sx, r_cz);
            r_p[11] <= rmul(r_cxsy, r_sz);
            r_p[12] <= rmul(r_cx, r_cy);
            r_p[13] <= '0;
            r_m[0] <= sat(r_p[0]);
            r_m[1] <= sat(r_p[1]);
            r_m[2] <= sat(r_p[2]);
            r_m[3] <= sat(r_p[3] + r_p[4]);
            r_m[4] <= sat(r_p[5] - r_p[6]);
            r_m[5] <= sat(r_p[7] + r_p[13]);
            r_m[6] <= sat(r_p[8] - r_p[9]);
            r_m[7] <= sat(r_p[10] + r_p[11]);
            r_m[8] <= sat(r_p[12]);
        end
    end

    assign o_m = r_m;
endmodule

// ===== hw/rtl/euler_xyz_pose_to_transform_unit.sv =====
`timescale 1ns / 1ps
// Channel | Handshake          | Payload
// in      | i_valid / o_stall  | i_origin_*, i_angle_*
// out     | o_valid / i_stall  | o_m00..o_m22, o_trans_*
// One transaction per cycle while i_stall is low.
// The CORDIC input register, stage chain and output register plus three matrix stages set the latency.
// Reset clears the valid bits only.
// An output stall freezes the whole pipeline; o_stall follows i_stall.
module euler_xyz_pose_to_transform_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [15:0]            i_angle_x,
    input  logic signed [15:0]            i_angle_y,
    input  logic signed [15:0]            i_angle_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COEF_WIDTH-1:0]  o_m00, o_m01, o_m02,
    output logic signed [COEF_WIDTH-1:0]  o_m10, o_m11, o_m12,
    output logic signed [COEF_WIDTH-1:0]  o_m20, o_m21, o_m22,
    output logic signed [COORD_WIDTH-1:0] o_trans_x,
    output logic signed [COORD_WIDTH-1:0] o_trans_y,
    output logic signed [COORD_WIDTH-1:0] o_trans_z
);
    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NS + 5;

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic signed [COORD_WIDTH-1:0] r_ox [LAT];
    logic signed [COORD_WIDTH-1:0] r_oy [LAT];
    logic signed [COORD_WIDTH-1:0] r_oz [LAT];
    logic signed [COEF_WIDTH-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;
    logic signed [COEF_WIDTH-1:0] w_m [9];

    assign w_en = !i_stall;
    assign o_stall = i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox[0] <= i_origin_x;
            r_oy[0] <= i_origin_y;
            r_oz[0] <= i_origin_z;
            for (int k = 1; k < LAT; k++) begin
                r_ox[k] <= r_ox[k-1];
                r_oy[k] <= r_oy[k-1];
                r_oz[k] <= r_oz[k-1];
            end
        end
    end

    exyz_cordic #(.COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cx (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_sin(w_sx), .o_cos(w_cx));
    exyz_cordic #(.COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cy (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_sin(w_sy), .o_cos(w_cy));
    exyz_cordic #(.COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cz (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_sin(w_sz), .o_cos(w_cz));

    exyz_matrix #(.COEF_WIDTH(COEF_WIDTH)) u_mat (
        .i_clk(i_clk), .i_en(w_en),
        .i_sx(w_sx), .i_cx(w_cx), .i_sy(w_sy), .i_cy(w_cy), .i_sz(w_sz), .i_cz(w_cz),
        .o_m(w_m));

    assign o_valid = r_vld[LAT-1];
    assign o_m00 = w_m[0]; assign o_m01 = w_m[1]; assign o_m02 = w_m[2];
    assign o_m10 = w_m[3]; assign o_m11 = w_m[4]; assign o_m12 = w_m[5];
    assign o_m20 = w_m[6]; assign o_m21 = w_m[7]; assign o_m22 = w_m[8];
    assign o_trans_x = r_ox[LAT-1];
    assign o_trans_y = r_oy[LAT-1];
    assign o_trans_z = r_oz[LAT-1];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |=> $stable(r_vld)) else $error("valid bits moved under stall");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_trans_x) && $stable(o_m00)))
        else $error("held result changed");
    a_stall_link: assert property (@(posedge i_clk) o_stall == i_stall)
        else $error("stall not forwarded");
endmodule

// ===== dv/euler_xyz_transform_checker.sv =====
`timescale 1ns / 1ps
module euler_xyz_transform_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [15:0]            i_angle_x,
    input  logic signed [15:0]            i_angle_y,
    input  logic signed [15:0]            i_angle_z,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic signed [COEF_WIDTH-1:0]  o_m00, o_m01, o_m02,
    input  logic signed [COEF_WIDTH-1:0]  o_m10, o_m11, o_m12,
    input  logic signed [COEF_WIDTH-1:0]  o_m20, o_m21, o_m22,
    input  logic signed [COORD_WIDTH-1:0] o_trans_x,
    input  logic signed [COORD_WIDTH-1:0] o_trans_y,
    input  logic signed [COORD_WIDTH-1:0] o_trans_z,
    output int                            o_errors,
    output int                            o_pending
);
    localparam int FB = COEF_WIDTH - 2;
    localparam longint ANG_LIM = 25736;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint HPI_Q = 64'sd1686629713;
    localparam longint GAIN_Q = 64'sd652032874;

    typedef struct {
        longint m[9];
        logic signed [COORD_WIDTH-1:0] t[3];
    } t_transform;

    t_transform transforms_due[$];
    longint atan_tab[32] = '{
        843314856, 497837829, 263043836, 133525158, 66987298, 33522745,
        16765412, 8383141, 4191634, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2, 1, 0};

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) <<< FB;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        int s;
        s = 30 - FB;
        if (s == 0) return clamp_unit(v);
        return clamp_unit((v + (longint'(1) <<< (s - 1))) >>> s);
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return (a * b + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    task automatic cordic_sincos(input logic signed [15:0] ang,
                                 output longint s, output longint c);
        longint a, x, y, t, dx, dy;
        bit flip;
        a = longint'(ang);
        x = GAIN_Q;
        y = 0;
        flip = 0;
        if (a > ANG_LIM) a = ANG_LIM;
        if (a < -ANG_LIM) a = -ANG_LIM;
        a = a * 131072;
        if (a > HPI_Q) begin
            a -= PI_Q;
            flip = 1;
        end else if (a < -HPI_Q) begin
            a += PI_Q;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                t = x - dx; y = y + dy; a -= atan_tab[i];
            end else begin
                t = x + dx; y = y - dy; a += atan_tab[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = round_q30(y);
        c = round_q30(x);
    endtask

    task automatic predict_transform;
        t_transform r;
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        cordic_sincos(i_angle_x, sx, cx);
        cordic_sincos(i_angle_y, sy, cy);
        cordic_sincos(i_angle_z, sz, cz);
        sxsy = round_mul(sx, sy);
        cxsy = round_mul(cx, sy);
        r.m[0] = clamp_unit(round_mul(cy, cz));
        r.m[1] = clamp_unit(-round_mul(cy, sz));
        r.m[2] = clamp_unit(sy);
        r.m[3] = clamp_unit(round_mul(cx, sz) + round_mul(sxsy, cz));
        r.m[4] = clamp_unit(round_mul(cx, cz) - round_mul(sxsy, sz));
        r.m[5] = clamp_unit(-round_mul(sx, cy));
        r.m[6] = clamp_unit(round_mul(sx, sz) - round_mul(cxsy, cz));
        r.m[7] = clamp_unit(round_mul(sx, cz) + round_mul(cxsy, sz));
        r.m[8] = clamp_unit(round_mul(cx, cy));
        r.t[0] = i_origin_x;
        r.t[1] = i_origin_y;
        r.t[2] = i_origin_z;
        transforms_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic compare_transform;
        t_transform w;
        logic signed [COEF_WIDTH-1:0] got[9];
        logic signed [COORD_WIDTH-1:0] gt[3];
        logic signed [COEF_WIDTH-1:0] wm;
        got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
        gt = '{o_trans_x, o_trans_y, o_trans_z};
        if (transforms_due.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
            return;
        end
        w = transforms_due.pop_front();
        for (int k = 0; k < 9; k++) begin
            wm = COEF_WIDTH'(w.m[k]);
            if (got[k] !== wm) report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                               longint'(got[k]), longint'(wm));
        end
        for (int k = 0; k < 3; k++)
            if (gt[k] !== w.t[k]) report_mismatch($sformatf("trans %0d", k),
                                                  longint'(gt[k]), longint'(w.t[k]));
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) compare_transform();
            if (i_valid && !o_stall) predict_transform();
        end
        o_pending = transforms_due.size();
    end
endmodule

// ===== dv/tb_euler_xyz_pose_to_transform_unit.sv =====
`timescale 1ns / 1ps
module tb_euler_xyz_pose_to_transform_unit;
    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int RANDOM_POSES = 850;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic signed [COORD_WIDTH-1:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [15:0] i_angle_x, i_angle_y, i_angle_z;
    logic signed [COEF_WIDTH-1:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12;
    logic signed [COEF_WIDTH-1:0] o_m20, o_m21, o_m22;
    logic signed [COORD_WIDTH-1:0] o_trans_x, o_trans_y, o_trans_z;
    int errors, pending, idle_cycles;
    bit calm_rx, hold_rx;

    euler_xyz_pose_to_transform_unit #(
        .COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (.*);

    euler_xyz_transform_checker #(
        .COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)
    ) i_checker (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(25730, 25742));
            2: return -16'($urandom_range(25730, 25742));
            3: return 16'($urandom_range(12860, 12880));
            4: return -16'($urandom_range(12860, 12880));
            default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
        endcase
    endfunction

    task automatic send_pose(input logic signed [31:0] ox, oy, oz,
                             input logic signed [15:0] ax, ay, az, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 13) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_angle_x <= ax; i_angle_y <= ay; i_angle_z <= az;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Receiver: random stalls, one calm stretch, and one long hold-off.
    initial begin
        i_stall = 1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rx) begin
                i_stall <= 1;
                repeat (120) @(posedge i_clk);
                hold_rx = 0;
            end
            i_stall <= !calm_rx && ($urandom_range(0, 99) < 13);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] edge_angles[10];
        edge_angles = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7FFF, -16'sh8000,
                        16'sd12868, -16'sd12868, 16'sd12869, 16'sd1, -16'sd1};
        idle_cycles = 0;
        calm_rx = 0;
        hold_rx = 0;
        i_rst_n = 0;
        i_valid = 0;
        {i_origin_x, i_origin_y, i_origin_z} = '0;
        {i_angle_x, i_angle_y, i_angle_z} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: angle extremes and quadrant folds on each axis.
        for (int k = 0; k < 10; k++)
            send_pose(32'sh7FFFFFFF, -32'sh80000000, k, edge_angles[k],
                      edge_angles[(k + 3) % 10], edge_angles[(k + 7) % 10], 1);
        send_pose(-32'sh80000000, 32'sh7FFFFFFF, -1, 16'sd25736, 16'sd25736, 16'sd25736, 1);
        send_pose(0, 0, 32'sh7FFFFFFF, -16'sh8000, -16'sh8000, -16'sh8000, 1);
        send_pose(32'sh55555555, 32'shAAAAAAAA, 0, 16'sd12868, 16'sd12868, -16'sd12868, 1);
        // Pause until the pipeline drains.
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        hold_rx = 1;
        for (int n = 0; n < RANDOM_POSES; n++) begin
            calm_rx = (n >= 300 && n < 420);
            send_pose($urandom, $urandom, $urandom, rand_angle(), rand_angle(), rand_angle(),
                      !calm_rx);
        end
        i_valid <= 0;
        calm_rx = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (CORDIC_STAGES + 10) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/exyz_pkg.sv
hw/rtl/exyz_cordic.sv
hw/rtl/exyz_matrix.sv
hw/rtl/euler_xyz_pose_to_transform_unit.sv
dv/euler_xyz_transform_checker.sv
dv/tb_euler_xyz_pose_to_transform_unit.sv
